FILE: hw/rtl/sts_pkg.sv
// ---------------------------------------------------------------------------
// sts_pkg
// Shared types, character codes and helpers for the script token splitter.
// ---------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

	localparam int MAX_TOKEN_LEN_DEF = 256;

	localparam logic [7:0] CH_HASH   = 8'h23;  // '#'
	localparam logic [7:0] CH_EQUAL  = 8'h3D;  // '='
	localparam logic [7:0] CH_LBRACK = 8'h5B;  // '['
	localparam logic [7:0] CH_RBRACK = 8'h5D;  // ']'
	localparam logic [7:0] CH_QUOTE  = 8'h22;  // '"'
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SKIP   = 8'hFF;  // skipped byte

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_COMMENT = 3'd1,
		MODE_TOKEN   = 3'd2,
		MODE_CLOSED  = 3'd4,
		MODE_QUOTE   = 3'd5
	} scan_mode_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [7:0] token_byte;
		logic       byte_valid;
		logic       token_end;
		logic       token_discarded;
	} out_item_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
	endfunction

	function automatic logic is_single(input logic [7:0] c);
		return (c == CH_EQUAL) || (c == CH_LBRACK) || (c == CH_RBRACK);
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sts_scan.sv
// ---------------------------------------------------------------------------
// sts_scan
// Next-state and result logic for one beat: current mode, length and held
// byte plus the incoming beat give the new state and at most one result.
// ---------------------------------------------------------------------------
`default_nettype none

module sts_scan import sts_pkg::*; #(
	parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
	localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1)
) (
	input  var scan_mode_t  mode,
	input  var logic [LEN_W-1:0] len,
	input  var logic [7:0]  held_byte,
	input  var logic        held_valid,
	input  var in_item_t    item,
	output scan_mode_t      mode_nxt,
	output logic [LEN_W-1:0] len_nxt,
	output logic [7:0]      held_byte_nxt,
	output logic            held_valid_nxt,
	output logic            emit,
	output out_item_t       result
);

	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LEN);
	localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

	logic [7:0]       c;
	logic [7:0]       ahead;
	logic [LEN_W-1:0] len_inc;

	assign c       = held_byte;
	assign ahead   = item.in_byte;
	assign len_inc = len + LEN_ONE;

	always_comb begin
		mode_nxt       = mode;
		len_nxt        = len;
		held_byte_nxt  = ahead;
		held_valid_nxt = 1'b1;
		emit           = 1'b0;
		result         = '0;
		if (item.end_of_input) begin
			// Stream end: drop any open token and forget the held byte.
			if (mode == MODE_TOKEN || mode == MODE_CLOSED || mode == MODE_QUOTE) begin
				emit                   = 1'b1;
				result.token_discarded = 1'b1;
			end
			mode_nxt       = MODE_IDLE;
			len_nxt        = '0;
			held_byte_nxt  = '0;
			held_valid_nxt = 1'b0;
		end else if (held_valid && c != CH_SKIP) begin
			case (mode)
				MODE_COMMENT: begin
					if (c == CH_LF)
						mode_nxt = MODE_IDLE;
				end
				MODE_TOKEN: begin
					if (is_blank(c)) begin
						mode_nxt         = MODE_IDLE;
						len_nxt          = '0;
						emit             = 1'b1;
						result.token_end = 1'b1;
					end else if (c == CH_HASH) begin
						mode_nxt = MODE_CLOSED;
					end else begin
						emit              = 1'b1;
						result.token_byte = c;
						result.byte_valid = 1'b1;
						len_nxt           = len_inc;
						if (len_inc >= LEN_MAX || is_single(c) || is_single(ahead)) begin
							mode_nxt         = MODE_IDLE;
							len_nxt          = '0;
							result.token_end = 1'b1;
						end
					end
				end
				MODE_CLOSED: begin
					if (c == CH_LF) begin
						mode_nxt         = MODE_IDLE;
						len_nxt          = '0;
						emit             = 1'b1;
						result.token_end = 1'b1;
					end
				end
				MODE_QUOTE: begin
					if (c == CH_QUOTE) begin
						mode_nxt         = MODE_IDLE;
						len_nxt          = '0;
						emit             = 1'b1;
						result.token_end = 1'b1;
					end else begin
						emit              = 1'b1;
						result.token_byte = c;
						result.byte_valid = 1'b1;
						len_nxt           = len_inc;
						if (len_inc >= LEN_MAX) begin
							mode_nxt         = MODE_IDLE;
							len_nxt          = '0;
							result.token_end = 1'b1;
						end
					end
				end
				default: begin
					// Idle, and any unused mode code behaves as idle.
					mode_nxt = MODE_IDLE;
					if (is_blank(c)) begin
						mode_nxt = MODE_IDLE;
					end else if (c == CH_HASH) begin
						mode_nxt = MODE_COMMENT;
					end else if (c == CH_QUOTE) begin
						mode_nxt = MODE_QUOTE;
						len_nxt  = '0;
					end else if (is_single(c) || is_single(ahead)) begin
						len_nxt           = '0;
						emit              = 1'b1;
						result.token_byte = c;
						result.byte_valid = 1'b1;
						result.token_end  = 1'b1;
					end else begin
						mode_nxt          = MODE_TOKEN;
						len_nxt           = LEN_ONE;
						emit              = 1'b1;
						result.token_byte = c;
						result.byte_valid = 1'b1;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/sts_out_reg.sv
// ---------------------------------------------------------------------------
// sts_out_reg
// Result register: holds one result beat until the consumer takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module sts_out_reg import sts_pkg::*; (
	input  var logic      clk,
	input  var logic      arst_n,
	input  var logic      load,
	input  var out_item_t load_data,
	output logic          free,
	output logic          rsp_valid,
	input  var logic      rsp_ready,
	output out_item_t     rsp
);

	logic      valid_q;
	out_item_t data_q;

	assign free      = !valid_q || rsp_ready;
	assign rsp_valid = valid_q;
	assign rsp       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (rsp_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			data_q <= load_data;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/script_token_splitter_core.sv
// ---------------------------------------------------------------------------
// script_token_splitter_core
// Splits a script byte stream into tokens with one byte of lookahead.
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  req     | req_valid/req_ready  | in_item_t  {in_byte, end_of_input}
//  rsp     | rsp_valid/rsp_ready  | out_item_t {token_byte, byte_valid,
//          |                      |             token_end, token_discarded}
//
//  One input beat per clock while req_ready is high. Each beat is decided
//  in the cycle it is taken, from the held byte, the scan mode and the token
//  length; a result lands in the result register and shows on rsp next cycle.
//  req_ready only drops while a result sits unread and rsp_ready is low.
//  Reset (arst_n low) returns to idle with nothing held and no result pending.
// ---------------------------------------------------------------------------
`default_nettype none

module script_token_splitter_core import sts_pkg::*; #(
	parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
	input  var logic      clk,
	input  var logic      arst_n,
	input  var logic      req_valid,
	output logic          req_ready,
	input  var in_item_t  req,
	output logic          rsp_valid,
	input  var logic      rsp_ready,
	output out_item_t     rsp
);

	localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

	// Scan state; the held byte is the byte being decided, the incoming
	// beat serves as its lookahead.
	scan_mode_t       mode_q;
	logic [LEN_W-1:0] len_q;
	logic [7:0]       held_byte_q;
	logic             held_valid_q;

	scan_mode_t       mode_nxt;
	logic [LEN_W-1:0] len_nxt;
	logic [7:0]       held_byte_nxt;
	logic             held_valid_nxt;
	logic             emit;
	out_item_t        result;

	logic accept;
	logic free;

	assign req_ready = free;
	assign accept    = req_valid && free;

	sts_scan #(
		.MAX_TOKEN_LEN(MAX_TOKEN_LEN)
	) u_scan (
		.mode           (mode_q),
		.len            (len_q),
		.held_byte      (held_byte_q),
		.held_valid     (held_valid_q),
		.item           (req),
		.mode_nxt       (mode_nxt),
		.len_nxt        (len_nxt),
		.held_byte_nxt  (held_byte_nxt),
		.held_valid_nxt (held_valid_nxt),
		.emit           (emit),
		.result         (result)
	);

	// Result beat goes out through its own register so the next input can be
	// taken in the same cycle the consumer takes this one.
	sts_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept && emit),
		.load_data (result),
		.free      (free),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			len_q        <= '0;
			held_byte_q  <= '0;
			held_valid_q <= 1'b0;
		end else if (accept) begin
			mode_q       <= mode_nxt;
			len_q        <= len_nxt;
			held_byte_q  <= held_byte_nxt;
			held_valid_q <= held_valid_nxt;
		end
	end

endmodule

`default_nettype wire

FILE: test/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for script_token_splitter_core. Beats go in on req and
// every accepted beat is run through a behavioral copy of the splitter. The
// token bytes, token ends and discards it produces are queued and compared
// against the rsp beats as they come out. Both sides idle at random, and
// one stretch holds rsp off long enough to back the block up.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import sts_pkg::*;

	localparam int TOKEN_CAP    = MAX_TOKEN_LEN_DEF;
	localparam int RANDOM_BEATS = 80;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 20;      // leave slack after the queue empties
	localparam int MAX_SHOWN    = 10;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	in_item_t  req       = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	out_item_t rsp;

	// Idle knobs, switched per phase by the test tasks
	bit src_idle = 1'b1;
	bit snk_idle = 1'b1;
	int rsp_hold = 0;  // one-shot long hold-off taken by the sink process

	// Scoreboard
	out_item_t token_beats_due[$];
	int        beats_sent      = 0;
	int        results_checked = 0;
	int        ends_seen       = 0;
	int        discards_seen   = 0;
	int        fault_count     = 0;
	int        cycle_count     = 0;

	// Behavioral splitter state
	scan_mode_t scan_state = MODE_IDLE;
	int         run_len    = 0;
	logic [7:0] held_char  = '0;
	bit         held_ok    = 1'b0;

	script_token_splitter_core #(
		.MAX_TOKEN_LEN(TOKEN_CAP)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	// Run limit; a stuck handshake or a lost result ends up here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due",
				cycle_count, token_beats_due.size());
			$display("tb: failure");
			$finish;
		end
	end

	// -----------------------------------------------------------------------
	// Splitter model
	// -----------------------------------------------------------------------

	function automatic bit is_gap(input logic [7:0] c);
		case (c)
			CH_SPACE, CH_TAB, CH_LF, CH_CR: return 1'b1;
			default:                        return 1'b0;
		endcase
	endfunction

	function automatic bit is_solo(input logic [7:0] c);
		case (c)
			CH_EQUAL, CH_LBRACK, CH_RBRACK: return 1'b1;
			default:                        return 1'b0;
		endcase
	endfunction

	// One input beat through the splitter; returns 1 when it yields a result.
	// The byte decided is the one held from the previous beat, and the byte
	// arriving now is only the lookahead.
	function automatic bit split_step(input in_item_t beat, output out_item_t res);
		logic [7:0] cur;
		logic [7:0] ahead;
		bit         had;
		bit         hit;
		res = '0;
		hit = 1'b0;
		if (beat.end_of_input) begin
			// a token in progress is dropped; comment or idle ends quietly
			if (scan_state inside {MODE_TOKEN, MODE_CLOSED, MODE_QUOTE}) begin
				res.token_discarded = 1'b1;
				hit = 1'b1;
			end
			scan_state = MODE_IDLE;
			run_len    = 0;
			held_char  = '0;
			held_ok    = 1'b0;
			return hit;
		end
		ahead     = beat.in_byte;
		cur       = held_char;
		had       = held_ok;
		held_char = ahead;
		held_ok   = 1'b1;
		if (!had || cur == CH_SKIP)
			return 1'b0;
		case (scan_state)
			MODE_COMMENT: begin
				if (cur == CH_LF)
					scan_state = MODE_IDLE;
			end
			MODE_TOKEN: begin
				if (is_gap(cur)) begin
					scan_state = MODE_IDLE;
					run_len = 0;
					res.token_end = 1'b1;
					hit = 1'b1;
				end else if (cur == CH_HASH) begin
					scan_state = MODE_CLOSED;  // end comes with the newline
				end else begin
					run_len++;
					res.token_byte = cur;
					res.byte_valid = 1'b1;
					hit = 1'b1;
					if (run_len >= TOKEN_CAP || is_solo(cur) || is_solo(ahead)) begin
						scan_state = MODE_IDLE;
						run_len = 0;
						res.token_end = 1'b1;
					end
				end
			end
			MODE_CLOSED: begin
				if (cur == CH_LF) begin
					scan_state = MODE_IDLE;
					run_len = 0;
					res.token_end = 1'b1;
					hit = 1'b1;
				end
			end
			MODE_QUOTE: begin
				hit = 1'b1;
				if (cur == CH_QUOTE) begin
					scan_state = MODE_IDLE;
					run_len = 0;
					res.token_end = 1'b1;
				end else begin
					run_len++;
					res.token_byte = cur;
					res.byte_valid = 1'b1;
					if (run_len >= TOKEN_CAP) begin
						scan_state = MODE_IDLE;
						run_len = 0;
						res.token_end = 1'b1;
					end
				end
			end
			default: begin
				scan_state = MODE_IDLE;
				if (is_gap(cur)) begin
					// nothing to do between tokens
				end else if (cur == CH_HASH) begin
					scan_state = MODE_COMMENT;
				end else if (cur == CH_QUOTE) begin
					scan_state = MODE_QUOTE;
					run_len = 0;
				end else begin
					res.token_byte = cur;
					res.byte_valid = 1'b1;
					hit = 1'b1;
					if (is_solo(cur) || is_solo(ahead)) begin
						run_len = 0;
						res.token_end = 1'b1;  // one-byte token
					end else begin
						scan_state = MODE_TOKEN;
						run_len = 1;
					end
				end
			end
		endcase
		return hit;
	endfunction

	// -----------------------------------------------------------------------
	// Req side
	// -----------------------------------------------------------------------

	// Offer one beat and block until it is taken. A zero gap keeps valid high
	// straight into the next beat.
	task automatic send_beat(input in_item_t beat);
		int        gap;
		out_item_t res;
		gap = src_idle ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= beat;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		beats_sent++;
		if (split_step(beat, res))
			token_beats_due.push_back(res);
	endtask

	task automatic send_char(input logic [7:0] c);
		in_item_t beat;
		beat.in_byte      = c;
		beat.end_of_input = 1'b0;
		send_beat(beat);
	endtask

	// the byte field is don't-care here, so it gets noise
	task automatic send_eoi();
		in_item_t beat;
		beat.in_byte      = 8'($urandom_range(0, 255));
		beat.end_of_input = 1'b1;
		send_beat(beat);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	function automatic logic [7:0] blank_char();
		case ($urandom_range(0, 3))
			0:       return CH_SPACE;
			1:       return CH_TAB;
			2:       return CH_LF;
			default: return CH_CR;
		endcase
	endfunction

	function automatic logic [7:0] solo_char();
		case ($urandom_range(0, 2))
			0:       return CH_EQUAL;
			1:       return CH_LBRACK;
			default: return CH_RBRACK;
		endcase
	endfunction

	// plain token byte: never a separator, comment, quote, solo or skip byte
	function automatic logic [7:0] word_char();
		string pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_./-";
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(8'h80, 8'hFE));
		return pool[$urandom_range(0, pool.len() - 1)];
	endfunction

	function automatic logic [7:0] quote_char();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
		return c;
	endfunction

	task automatic send_word(input int n);
		repeat (n) send_char(word_char());
	endtask

	task automatic send_quoted(input int n);
		send_char(CH_QUOTE);
		repeat (n) send_char(quote_char());
		send_char(CH_QUOTE);
	endtask

	task automatic send_comment(input int n);
		logic [7:0] c;
		send_char(CH_HASH);
		repeat (n) begin
			c = ($urandom_range(0, 3) == 0) ? CH_SPACE : word_char();
			send_char(c);
		end
		send_char(CH_LF);
	endtask

	// -----------------------------------------------------------------------
	// Rsp side
	// -----------------------------------------------------------------------

	// Sink: per beat a random hold-off, or the long one when a test asks.
	initial begin : sink_side
		int hold_n;
		forever begin
			hold_n = snk_idle ? $urandom_range(0, 16) : 0;
			if (rsp_hold > 0) begin
				hold_n   = rsp_hold;
				rsp_hold = 0;
			end
			if (hold_n > 0) begin
				rsp_ready <= 1'b0;
				repeat (hold_n) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	task automatic note_fault(input string msg);
		fault_count++;
		if (fault_count <= MAX_SHOWN)
			$display("[%0t] %s", $time, msg);
	endtask

	// Checker: each rsp beat against the oldest prediction
	always @(posedge clk) begin : rsp_check
		out_item_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (token_beats_due.size() == 0) begin
				note_fault($sformatf("unexpected result: byte %02h valid %b end %b discard %b",
					rsp.token_byte, rsp.byte_valid, rsp.token_end, rsp.token_discarded));
			end else begin
				want = token_beats_due.pop_front();
				if (rsp.token_byte !== want.token_byte ||
					rsp.byte_valid !== want.byte_valid ||
					rsp.token_end !== want.token_end ||
					rsp.token_discarded !== want.token_discarded) begin
					note_fault($sformatf({"result %0d mismatch: expected byte %02h valid %b",
						" end %b discard %b, got byte %02h valid %b end %b discard %b"},
						results_checked, want.token_byte, want.byte_valid, want.token_end,
						want.token_discarded, rsp.token_byte, rsp.byte_valid,
						rsp.token_end, rsp.token_discarded));
				end
				if (want.token_end)
					ends_seen++;
				if (want.token_discarded)
					discards_seen++;
			end
			results_checked++;
		end
	end

	// -----------------------------------------------------------------------
	// Tests
	// -----------------------------------------------------------------------

	// Hand-picked stream: first beat with nothing held, solo bytes at the
	// start and as lookahead, empty quotes, a solo byte behind a skipped 0xFF,
	// a comment closing a token, quoted blank, byte extremes, and a token cut
	// by a comment when input ends.
	task automatic test_directed();
		send_text("k=v \"\" a");
		send_char(CH_SKIP);
		send_text("]b#c\n[\"q \"\r");
		send_char(8'h00);
		send_char(CH_TAB);
		send_char(8'h80);
		send_char(8'h7F);
		send_char(CH_HASH);
		send_eoi();
	endtask

	// End of input in a token, in quotes, in a comment,
	// with nothing held, and with only one byte held.
	task automatic test_end_of_input();
		send_text("ab");
		send_eoi();
		send_text("\"x");
		send_eoi();
		send_text("#z");
		send_eoi();
		send_eoi();
		send_text("w");
		send_eoi();
	endtask

	// Tokens that run into the length cap, plain and quoted; no idling here.
	task automatic test_token_cap();
		src_idle = 1'b0;
		snk_idle = 1'b0;
		send_word(TOKEN_CAP + 44);
		send_char(CH_SPACE);
		send_quoted(TOKEN_CAP + 4);
		send_eoi();
		src_idle = 1'b1;
		snk_idle = 1'b1;
	endtask

	// Sink holds off for a long stretch while words keep coming, so the
	// result register fills and req_ready has to drop.
	task automatic test_stall_fill();
		src_idle = 1'b0;
		snk_idle = 1'b0;
		rsp_hold = 400;
		repeat (30) begin
			send_word($urandom_range(2, 8));
			send_char(CH_SPACE);
		end
		src_idle = 1'b1;
		snk_idle = 1'b1;
	endtask

	// Mostly well-formed script text with random content; noise bytes, skip
	// bytes and stray end-of-input beats mixed in. Idling toggles at random.
	task automatic test_random_stream();
		int start;
		int pick;
		start = beats_sent;
		while (beats_sent - start < RANDOM_BEATS) begin
			if ($urandom_range(0, 59) == 0) begin
				src_idle = 1'($urandom_range(0, 1));
				snk_idle = 1'($urandom_range(0, 1));
			end
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				send_word($urandom_range(1, 10));
				send_char(blank_char());
			end else if (pick < 50) begin
				// key=value and bracket forms
				send_word($urandom_range(1, 6));
				send_char(solo_char());
				if ($urandom_range(0, 1))
					send_word($urandom_range(1, 6));
			end else if (pick < 62) begin
				send_quoted($urandom_range(0, 12));
			end else if (pick < 72) begin
				if ($urandom_range(0, 1))
					send_word($urandom_range(1, 4));  // token cut by the comment
				send_comment($urandom_range(0, 10));
			end else if (pick < 79) begin
				send_char(CH_SKIP);
			end else if (pick < 92) begin
				send_char(8'($urandom_range(0, 255)));
			end else if (pick < 96) begin
				send_eoi();
			end else begin
				repeat ($urandom_range(1, 4)) send_char(blank_char());
			end
		end
		src_idle = 1'b1;
		snk_idle = 1'b1;
	endtask

	// -----------------------------------------------------------------------
	// Main sequence
	// -----------------------------------------------------------------------

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_end_of_input();
		test_token_cap();
		test_stall_fill();
		test_random_stream();

		req_valid <= 1'b0;
		while (token_beats_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d beats in, %0d results checked (%0d token ends, %0d discards)",
			beats_sent, results_checked, ends_seen, discards_seen);
		$display("summary: %0d faults over directed, end-of-input, cap, stall and random runs",
			fault_count);
		if (fault_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
